>>> src/dssd_pkg.sv
// Shared types, constants and the segment table for the decimal seven-segment encoder.
package dssd_pkg;

  localparam int VALUE_W         = 32;
  localparam int LOW_W           = 32;
  localparam int SEG_W           = 7;
  localparam int LOW_SPAN        = 28;
  localparam int DIGIT_WIDTH_DEF = 7;
  localparam int PROD_W          = 2 * VALUE_W;
  localparam int QUOT_W          = VALUE_W - 3;
  localparam int RECIP_SHIFT     = 35;
  localparam logic [VALUE_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_DONE
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic mul;
    logic upd;
    logic fifth_sel;
    logic out_load;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic quot_zero;
  } status_t;

  // Active-high segment pattern (g..a) of one decimal digit.
  function automatic logic [SEG_W-1:0] seg_encode(input logic [3:0] digit);
    logic [SEG_W-1:0] seg;
    unique case (digit)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7D;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h6F;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

>>> src/dssd_ctrl.sv
// Controller state machine: sequences the per-digit divide steps and the result register.
module dssd_ctrl
  import dssd_pkg::*;
#(
  parameter int DIGIT_WIDTH = DIGIT_WIDTH_DEF,
  parameter int NUM_LOW     = (LOW_SPAN + DIGIT_WIDTH - 1) / DIGIT_WIDTH,
  parameter int DIG_CNT_W   = $clog2(NUM_LOW + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  status_t              status,
  output cmd_t                 cmd,
  output logic [DIG_CNT_W-1:0] dig_idx
);

  state_t               state_r, state_nxt;
  logic [DIG_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 fifth_sel;
  logic                 last_digit;
  logic                 out_free;

  assign fifth_sel  = (cnt_r == DIG_CNT_W'(NUM_LOW));
  assign last_digit = status.quot_zero || fifth_sel;
  assign out_free   = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_UPD;
      ST_UPD:  state_nxt = last_digit ? ST_DONE : ST_MUL;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    cmd.fifth_sel = fifth_sel;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MUL:  cmd.mul = 1'b1;
      ST_UPD:  cmd.upd = 1'b1;
      ST_DONE: cmd.out_load = out_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      cnt_nxt = '0;
    end else if (cmd.upd) begin
      cnt_nxt = cnt_r + DIG_CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign dig_idx   = cnt_r;

endmodule

>>> src/dssd_dp.sv
// Datapath: divide-by-ten by reciprocal multiply, segment packing and result register.
module dssd_dp
  import dssd_pkg::*;
#(
  parameter int DIGIT_WIDTH = DIGIT_WIDTH_DEF,
  parameter int NUM_LOW     = (LOW_SPAN + DIGIT_WIDTH - 1) / DIGIT_WIDTH,
  parameter int DIG_CNT_W   = $clog2(NUM_LOW + 1)
) (
  input  logic                 clk,
  input  cmd_t                 cmd,
  input  logic [DIG_CNT_W-1:0] dig_idx,
  output status_t              status,
  input  logic [VALUE_W-1:0]   in_value,
  output logic [LOW_W-1:0]     out_low_four_digits,
  output logic [SEG_W-1:0]     out_fifth_digit
);

  localparam int SHAMT_W = $clog2(LOW_W);

  logic [VALUE_W-1:0] n_r,     n_nxt;
  logic [PROD_W-1:0]  prod_r;
  logic [LOW_W-1:0]   lit_r,   lit_nxt;
  logic [SEG_W-1:0]   fifth_r, fifth_nxt;
  logic [LOW_W-1:0]   out_low_r;
  logic [SEG_W-1:0]   out_fifth_r;

  logic [QUOT_W-1:0]  quot;
  logic [VALUE_W-1:0] quot_ext;
  logic [VALUE_W-1:0] ten_quot;
  logic [VALUE_W-1:0] diff;
  logic [SEG_W-1:0]   seg;
  logic [SHAMT_W-1:0] shamt;

  // Quotient and remainder of n / 10 from the registered product.
  assign quot     = prod_r[PROD_W-1:RECIP_SHIFT];
  assign quot_ext = VALUE_W'(quot);
  assign ten_quot = (quot_ext << 3) + (quot_ext << 1);
  assign diff     = n_r - ten_quot;
  assign seg      = seg_encode(diff[3:0]);
  assign shamt    = SHAMT_W'(dig_idx * DIGIT_WIDTH);

  assign status.quot_zero = (quot == '0);

  always_comb begin
    n_nxt     = n_r;
    lit_nxt   = lit_r;
    fifth_nxt = fifth_r;
    if (cmd.load) begin
      n_nxt     = in_value;
      lit_nxt   = '0;
      fifth_nxt = '0;
    end else if (cmd.upd) begin
      n_nxt = quot_ext;
      if (cmd.fifth_sel) begin
        fifth_nxt = seg;
      end else begin
        lit_nxt = lit_r | (LOW_W'(seg) << shamt);
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    lit_r   <= lit_nxt;
    fifth_r <= fifth_nxt;
    if (cmd.mul) begin
      prod_r <= PROD_W'(n_r) * PROD_W'(RECIP_TEN);
    end
    if (cmd.out_load) begin
      out_low_r   <= ~lit_r;
      out_fifth_r <= ~fifth_r;
    end
  end

  assign out_low_four_digits = out_low_r;
  assign out_fifth_digit     = out_fifth_r;

endmodule

>>> src/decimal_seven_segment_display_encoder_top.sv
// Top level of the decimal seven-segment display encoder.
//
//   channel | ports                                    | direction
//   --------+------------------------------------------+----------
//   input   | in_valid, in_ready, in_value[31:0]       | in
//   result  | out_valid, out_ready,                    | out
//           | out_low_four_digits[31:0],               |
//           | out_fifth_digit[6:0]                     |
//
// Per item: an accept step in idle, then a multiply step and an update step per
// decimal digit produced (1 to 5 digits, ending at the first zero quotient or
// at the fifth digit), and a done step that loads the result register. The
// divide-by-ten step is a 32x32 reciprocal multiply, registered, then a
// subtract for the remainder.
// Reset (rst_n low, synchronous) returns the controller to idle and drops any
// pending result. A stalled result holds in the output register while the
// next item is taken and worked on; that item then waits in its last state
// until the register drains.
module decimal_seven_segment_display_encoder_top
  import dssd_pkg::*;
#(
  parameter int DIGIT_WIDTH = DIGIT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [LOW_W-1:0]   out_low_four_digits,
  output logic [SEG_W-1:0]   out_fifth_digit
);

  // Digit slots that start below the packed span, and a counter wide enough
  // to also name the fifth digit.
  localparam int NUM_LOW   = (LOW_SPAN + DIGIT_WIDTH - 1) / DIGIT_WIDTH;
  localparam int DIG_CNT_W = $clog2(NUM_LOW + 1);

  cmd_t                 cmd;
  status_t              status;
  logic [DIG_CNT_W-1:0] dig_idx;

  // Controller: owns the state, the digit count and the result valid flag.
  dssd_ctrl #(
    .DIGIT_WIDTH(DIGIT_WIDTH),
    .NUM_LOW    (NUM_LOW),
    .DIG_CNT_W  (DIG_CNT_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .cmd      (cmd),
    .dig_idx  (dig_idx)
  );

  // Datapath: working quotient, product, segment accumulators, result payload.
  dssd_dp #(
    .DIGIT_WIDTH(DIGIT_WIDTH),
    .NUM_LOW    (NUM_LOW),
    .DIG_CNT_W  (DIG_CNT_W)
  ) u_dp (
    .clk                (clk),
    .cmd                (cmd),
    .dig_idx            (dig_idx),
    .status             (status),
    .in_value           (in_value),
    .out_low_four_digits(out_low_four_digits),
    .out_fifth_digit    (out_fifth_digit)
  );

endmodule

>>> src/dssd_checker.sv
// Port-level checker for the decimal seven-segment encoder, with its bind.
module dssd_checker
  import dssd_pkg::*;
#(
  parameter int DIGIT_WIDTH = DIGIT_WIDTH_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [VALUE_W-1:0] in_value,
  input logic               out_valid,
  input logic               out_ready,
  input logic [LOW_W-1:0]   out_low_four_digits,
  input logic [SEG_W-1:0]   out_fifth_digit
);

  localparam int TOP_SLOT = 3 * DIGIT_WIDTH;

  // Hold a stalled result.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_low_four_digits)
      && $stable(out_fifth_digit))
    else $error("stalled result changed");

  // One item at a time: no transfer right after a transfer.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // The top bit of the packed word is never a segment.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_low_four_digits[LOW_W-1])
    else $error("top word bit lit");

  // A shown fifth digit implies a shown fourth digit.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_fifth_digit != {SEG_W{1'b1}})
      |-> (out_low_four_digits[TOP_SLOT +: SEG_W] != {SEG_W{1'b1}}))
    else $error("fifth digit shown over blank fourth");

  // Hold a waiting input transfer, payload unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_value))
    else $error("input dropped or changed before transfer");

endmodule

bind decimal_seven_segment_display_encoder_top dssd_checker #(
  .DIGIT_WIDTH(DIGIT_WIDTH)
) u_chk (.*);
